// ----- sv/lpss_pkg.sv -----
// ----------------------------------------------------------------------------
// lpss_pkg
// Types and constants shared by the LED pattern state stack block.
// ----------------------------------------------------------------------------
package lpss_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK      = 3'd0,
    MODE_SET       = 3'd1,
    MODE_SET_DELAY = 3'd2,
    MODE_REVERT    = 3'd3,
    MODE_TOGGLE    = 3'd4,
    MODE_FORCE     = 3'd5
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SLOW_HALF  = 4'd0,
    REG_FAST_HALF  = 4'd1,
    REG_SOS_SHORT  = 4'd2,
    REG_SOS_LONG   = 4'd3
  } cfg_reg_e;

  typedef logic [CodeW-1:0] code_t;

  localparam code_t ST_UNCTRL      = 4'd0;
  localparam code_t ST_OFF         = 4'd1;
  localparam code_t ST_ON          = 4'd2;
  localparam code_t ST_SLOW        = 4'd3;
  localparam code_t ST_SOS         = 4'd4;
  localparam code_t ST_FAST        = 4'd5;
  localparam code_t ST_WAIT_TOGGLE = 4'd6;
  localparam code_t ST_WAIT_OFF    = 4'd7;
  localparam code_t ST_WAIT_ON     = 4'd8;

  // last SOS step of each phase
  localparam logic [3:0] SOS_SHORT_LAST = 4'd5;
  localparam logic [3:0] SOS_LONG_LAST  = 4'd11;

  localparam logic [PeriodW-1:0] SLOW_HALF_RST = 16'd1000;
  localparam logic [PeriodW-1:0] FAST_HALF_RST = 16'd100;
  localparam logic [PeriodW-1:0] SOS_SHORT_RST = 16'd150;
  localparam logic [PeriodW-1:0] SOS_LONG_RST  = 16'd400;

endpackage

// ----- sv/lpss_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lpss_cmd_if
// Command channel: mode, state code, delay and forced LED level.
// ----------------------------------------------------------------------------
interface lpss_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  state_code;
  logic [15:0] delay_ms;
  logic        led_value;

  modport source (output valid, mode, state_code, delay_ms, led_value, input ready);
  modport sink   (input valid, mode, state_code, delay_ms, led_value, output ready);
endinterface

// ----- sv/lpss_res_if.sv -----
// ----------------------------------------------------------------------------
// lpss_res_if
// Result channel: LED level, active state, stack level and drop flag.
// ----------------------------------------------------------------------------
interface lpss_res_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic [3:0] active_state;
  logic [3:0] stack_level;
  logic       push_dropped;

  modport source (output valid, led_on, active_state, stack_level, push_dropped,
                  input ready);
  modport sink   (input valid, led_on, active_state, stack_level, push_dropped,
                  output ready);
endinterface

// ----- sv/lpss_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lpss_cfg_if
// Configuration write channel: register address and write data.
// ----------------------------------------------------------------------------
interface lpss_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- sv/led_pattern_state_stack.sv -----
// ----------------------------------------------------------------------------
// led_pattern_state_stack
// LED drive controller with a bounded stack of states.
// ----------------------------------------------------------------------------
// Result word valid in the cycle after the command word is accepted.
// Throughput: one command word per cycle while res_o.ready is high. The top of
// stack is registered; the entry below is prefetched from RAM every cycle.
// Reset: stack empty, LED off, time, deadline and SOS step zero, periods at
// their defaults. Stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module led_pattern_state_stack
  import lpss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  lpss_cmd_if.sink   cmd_i,
  lpss_res_if.source res_o,
  lpss_cfg_if.sink   cfg_i
);

  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [SpW-1:0]     sp_q, sp_d;
  code_t              top_q, top_d;
  logic               led_q, led_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic [TimeW-1:0]   dl_q, dl_d;
  logic [3:0]         sos_q, sos_d;
  logic [PeriodW-1:0] slow_q, fast_q, short_q, long_q;

  logic        res_valid_q;
  logic        res_led_q;
  code_t       res_state_q;
  logic [3:0]  res_level_q;
  logic        res_drop_q;

  logic        accept;
  logic        do_push, do_pop, do_clear, drop;
  code_t       push_code, top_cur, below;
  logic [SpW-1:0] base;
  logic        wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [SpW-1:0]   rd_sp;
  code_t       cmd_code;

  assign cmd_i.ready = ~res_valid_q | res_o.ready;
  assign accept      = cmd_i.valid & cmd_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cmd_code    = cmd_i.state_code;
  assign top_cur     = (sp_q == '0) ? ST_UNCTRL : top_q;

  always_comb begin
    sp_d      = sp_q;
    top_d     = top_q;
    led_d     = led_q;
    now_d     = now_q;
    dl_d      = dl_q;
    sos_d     = sos_q;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_clear  = 1'b0;
    push_code = ST_WAIT_TOGGLE;
    drop      = 1'b0;
    wr_en     = 1'b0;
    if (accept) begin
      case (cmd_i.mode) inside
        MODE_TICK: begin
          now_d = now_q + 1'b1;
          case (top_cur)
            ST_OFF: led_d = 1'b0;
            ST_ON:  led_d = 1'b1;
            ST_SLOW: begin
              dl_d    = now_d + TimeW'(slow_q);
              do_push = 1'b1;
            end
            ST_FAST: begin
              dl_d    = now_d + TimeW'(fast_q);
              do_push = 1'b1;
            end
            ST_SOS: begin
              if (sos_q <= SOS_SHORT_LAST) begin
                dl_d    = now_d + TimeW'(short_q);
                do_push = 1'b1;
                sos_d   = sos_q + 1'b1;
              end else if (sos_q <= SOS_LONG_LAST) begin
                dl_d    = now_d + TimeW'(long_q);
                do_push = 1'b1;
                sos_d   = sos_q + 1'b1;
              end else begin
                led_d = 1'b0;
                sos_d = '0;
              end
            end
            ST_WAIT_TOGGLE: begin
              if (now_d > dl_q) begin
                led_d  = ~led_q;
                do_pop = 1'b1;
              end
            end
            ST_WAIT_OFF: begin
              if (now_d > dl_q) begin
                led_d  = 1'b0;
                do_pop = 1'b1;
              end
            end
            ST_WAIT_ON: begin
              if (now_d > dl_q) begin
                led_d  = 1'b1;
                do_pop = 1'b1;
              end
            end
            default: ;
          endcase
        end
        MODE_SET, MODE_SET_DELAY: begin
          if (cmd_i.mode == MODE_SET_DELAY) begin
            dl_d = now_q + TimeW'(cmd_i.delay_ms);
          end
          push_code = cmd_code;
          if (cmd_code <= ST_FAST) begin
            do_clear = 1'b1;
            do_push  = 1'b1;
            dl_d     = '0;
          end else if (cmd_code <= ST_WAIT_ON) begin
            do_push = 1'b1;
          end
        end
        MODE_REVERT: do_pop = 1'b1;
        MODE_TOGGLE: led_d  = ~led_q;
        MODE_FORCE:  led_d  = cmd_i.led_value;
        default: ;
      endcase
    end

    base = do_clear ? '0 : sp_q;
    if (do_push) begin
      if (base >= SpW'(STACK_DEPTH)) begin
        drop = 1'b1;
        sp_d = base;
      end else begin
        wr_en = 1'b1;
        sp_d  = base + 1'b1;
        top_d = push_code;
      end
    end else if (do_pop && sp_q != '0) begin
      sp_d  = sp_q - 1'b1;
      top_d = below;
    end
  end

  assign wr_addr = base[AddrW-1:0];
  // prefetch the entry under the next top of stack
  assign rd_sp   = sp_d - SpW'(2);
  assign rd_addr = rd_sp[AddrW-1:0];

  lpss_ram #(
    .Width (CodeW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (push_code),
    .raddr_i (rd_addr),
    .rdata_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      top_q <= ST_UNCTRL;
      led_q <= 1'b0;
      now_q <= '0;
      dl_q  <= '0;
      sos_q <= '0;
    end else begin
      sp_q  <= sp_d;
      top_q <= top_d;
      led_q <= led_d;
      now_q <= now_d;
      dl_q  <= dl_d;
      sos_q <= sos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q  <= SLOW_HALF_RST;
      fast_q  <= FAST_HALF_RST;
      short_q <= SOS_SHORT_RST;
      long_q  <= SOS_LONG_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_SLOW_HALF: slow_q  <= cfg_i.data;
        REG_FAST_HALF: fast_q  <= cfg_i.data;
        REG_SOS_SHORT: short_q <= cfg_i.data;
        REG_SOS_LONG:  long_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_led_q   <= led_d;
      res_state_q <= (sp_d == '0) ? ST_UNCTRL : top_d;
      res_level_q <= 4'(sp_d);
      res_drop_q  <= drop;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.led_on       = res_led_q;
  assign res_o.active_state = res_state_q;
  assign res_o.stack_level  = res_level_q;
  assign res_o.push_dropped = res_drop_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_drop_q |-> sp_q == SpW'(STACK_DEPTH))
    else $error("push dropped while stack not full");

  a_time_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && cmd_i.mode == MODE_TICK) |=> $stable(now_q))
    else $error("time advanced without a tick");

  a_sos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sos_q <= SOS_LONG_LAST + 4'd1)
    else $error("SOS step out of range");

endmodule

// ----- sv/lpss_ram.sv -----
// ----------------------------------------------------------------------------
// lpss_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module lpss_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
